/* src/ppjs_pkg.sv */
// shared types and constants for the priority job scheduler
package ppjs_pkg;

  // request codes
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // policy codes
  localparam logic [1:0] POL_NONPREEMPT = 2'd0;
  localparam logic [1:0] POL_RESTART    = 2'd1;
  localparam logic [1:0] POL_RESUME     = 2'd2;

  // register indexes
  localparam int unsigned REG_POLICY = 0;

  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned DEMAND_W = 16;
  localparam int unsigned REPORT_W = 32;
  localparam int unsigned QLEN_W   = 5;

  // cell row commands
  typedef enum logic [1:0] {
    ROW_HOLD   = 2'd0,
    ROW_INSERT = 2'd1,
    ROW_POP    = 2'd2
  } row_op_t;

endpackage

/* src/ppjs_if.sv */
// valid/ready channel interfaces for requests and results
interface ppjs_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [ppjs_pkg::CLASS_W-1:0]      job_class;
  logic [ppjs_pkg::DEMAND_W-1:0]     service_demand;
  modport source (output valid, req_type, job_class, service_demand, input ready);
  modport sink (input valid, req_type, job_class, service_demand, output ready);
endinterface

interface ppjs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              completed;
  logic [ppjs_pkg::CLASS_W-1:0]      done_class;
  logic [ppjs_pkg::REPORT_W-1:0]     response_time;
  logic [ppjs_pkg::REPORT_W-1:0]     extended_service_time;
  logic [ppjs_pkg::REPORT_W-1:0]     initial_wait;
  logic [ppjs_pkg::QLEN_W-1:0]       queue_length;
  logic                              server_busy;
  logic                              dropped;
  modport source (output valid, completed, done_class, response_time,
                  extended_service_time, initial_wait, queue_length, server_busy,
                  dropped, input ready);
  modport sink (input valid, completed, done_class, response_time,
                extended_service_time, initial_wait, queue_length, server_busy,
                dropped, output ready);
endinterface

/* src/ppjs_cell.sv */
// one queue slot: holds a waiting job and shifts with its neighbors
module ppjs_cell #(
  parameter int unsigned TW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppjs_pkg::row_op_t             op,
  input  logic [ppjs_pkg::CLASS_W-1:0]  ins_class,
  input  logic                          prev_occ,
  input  logic                          prev_goes_right,
  input  logic [TW*2+ppjs_pkg::DEMAND_W*2+ppjs_pkg::CLASS_W:0] new_data,
  input  logic [TW*2+ppjs_pkg::DEMAND_W*2+ppjs_pkg::CLASS_W:0] left_data,
  input  logic [TW*2+ppjs_pkg::DEMAND_W*2+ppjs_pkg::CLASS_W:0] right_data,
  input  logic                          right_occ,
  input  logic                          at_head,
  output logic                          occ,
  output logic                          goes_right,
  output logic [ppjs_pkg::CLASS_W-1:0]  cls,
  output logic [TW*2+ppjs_pkg::DEMAND_W*2+ppjs_pkg::CLASS_W:0] data
);
  import ppjs_pkg::*;

  // this slot and everything after it moves one step toward the tail
  logic take_here;

  assign cls = data[CLASS_W-1:0];
  // a slot shifts when it holds a job of strictly larger class, or head insert
  assign goes_right = occ && (at_head || (cls > ins_class) || prev_goes_right);
  assign take_here  = goes_right && !prev_goes_right;

  // control: occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      case (op)
        ROW_INSERT: if (!occ && prev_occ) occ <= 1'b1;
        ROW_POP:    occ <= right_occ;
        default:    occ <= occ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (op)
      ROW_INSERT: begin
        if (prev_goes_right) data <= left_data;
        else if (take_here || (!occ && prev_occ)) data <= new_data;
      end
      ROW_POP: data <= right_data;
      default: data <= data;
    endcase
  end
endmodule

/* src/ppjs_row.sv */
// row of queue cells forming the sorted waiting line
module ppjs_row #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned TW    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppjs_pkg::row_op_t             op,
  input  logic                          at_head,
  input  logic [ppjs_pkg::CLASS_W-1:0]  ins_class,
  input  logic [TW*2+ppjs_pkg::DEMAND_W*2+ppjs_pkg::CLASS_W:0] new_data,
  output logic [TW*2+ppjs_pkg::DEMAND_W*2+ppjs_pkg::CLASS_W:0] head_data,
  output logic                          full,
  output logic                          empty
);
  import ppjs_pkg::*;
  localparam int unsigned DW = TW*2 + DEMAND_W*2 + CLASS_W + 1;

  logic [DEPTH-1:0]       occ;
  logic [DEPTH-1:0]       gr;
  logic [CLASS_W-1:0]     cls [DEPTH];
  logic [DW-1:0]          data [DEPTH];
  logic [DEPTH-1:0]       p_occ;
  logic [DEPTH-1:0]       p_gr;
  logic [DEPTH-1:0]       r_occ;
  logic [DW-1:0]          l_data [DEPTH];
  logic [DW-1:0]          r_data [DEPTH];

  // neighbor wiring; a virtual occupied slot sits before the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign p_occ[i]  = 1'b1;
      assign p_gr[i]   = 1'b0;
      assign l_data[i] = new_data;
    end else begin : g_mid
      assign p_occ[i]  = occ[i-1];
      assign p_gr[i]   = gr[i-1];
      assign l_data[i] = data[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign r_occ[i]  = 1'b0;
      assign r_data[i] = data[i];
    end else begin : g_inner
      assign r_occ[i]  = occ[i+1];
      assign r_data[i] = data[i+1];
    end
    ppjs_cell #(.TW(TW)) u_cell (
      .clk(clk), .rst(rst), .op(op), .ins_class(ins_class),
      .prev_occ(p_occ[i]), .prev_goes_right(p_gr[i]),
      .new_data(new_data), .left_data(l_data[i]), .right_data(r_data[i]),
      .right_occ(r_occ[i]), .at_head(at_head), .occ(occ[i]), .goes_right(gr[i]),
      .cls(cls[i]), .data(data[i])
    );
  end

  assign head_data = data[0];
  assign full      = occ[DEPTH-1];
  assign empty     = !occ[0];

`ifndef ASSERT_OFF
  // occupied slots stay packed at the head
  for (genvar k = 1; k < DEPTH; k++) begin : g_chk
    a_packed: assert property (@(posedge clk) disable iff (rst) occ[k] |-> occ[k-1])
      else $error("queue slots not contiguous");
  end
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (op == ROW_INSERT) |-> !full) else $error("insert into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (op == ROW_POP) |-> !empty) else $error("pop from empty queue");
`endif
endmodule

/* src/preemptive_priority_job_scheduler.sv */
// top level: priority job scheduler with server state and apb register
// a request is accepted when valid and ready; its result is registered from the accepting cycle
// flow: a new request is taken only once the previous result has left the output
//   register (ready is held low while rsp.valid is set); the queue cells shift at most once per request
// reset: synchronous active high; clears time, server, queue occupancy and policy
module preemptive_priority_job_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NUM_CLASSES = 5,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  ppjs_req_if.sink    req,
  ppjs_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppjs_pkg::*;
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned DW = TW*2 + DEMAND_W*2 + CLASS_W + 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);
  localparam logic [CLASS_W-1:0] MAX_CLASS = CLASS_W'(NUM_CLASSES-1);

  logic [1:0]          policy;
  logic [TW-1:0]       now_ticks;
  logic [CW-1:0]       wait_count;
  logic                srv_busy;
  logic [CLASS_W-1:0]  srv_class;
  logic [TW-1:0]       srv_arrival;
  logic [DEMAND_W-1:0] srv_demand;
  logic [DEMAND_W-1:0] srv_remaining;
  logic [TW-1:0]       srv_first_start;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_NONPREEMPT;
    end else if (psel && penable && pwrite && paddr == 2'(REG_POLICY*4)) begin
      policy <= pwdata[1:0];
    end
  end
  assign prdata = (paddr == 2'(REG_POLICY*4)) ? {30'd0, policy} : 32'd0;

  // request decode
  logic               acc;
  logic [CLASS_W-1:0] cls_in;
  logic               preempt_pol;
  logic               full, empty;
  logic [DW-1:0]      head_data;
  assign acc         = req.valid && req.ready;
  assign req.ready   = !rsp.valid;
  assign cls_in      = (req.job_class > MAX_CLASS) ? MAX_CLASS : req.job_class;
  assign preempt_pol = (policy == POL_RESTART) || (policy == POL_RESUME);

  logic is_arr, do_load, do_drop, do_preempt, do_enq;
  logic [DEMAND_W-1:0] rem_dec;
  logic do_done, do_pop;
  assign is_arr     = acc && req.req_type == REQ_ARRIVAL;
  assign do_load    = is_arr && !srv_busy;
  assign do_drop    = is_arr && srv_busy && full;
  assign do_preempt = is_arr && srv_busy && !full && preempt_pol && cls_in < srv_class;
  assign do_enq     = is_arr && srv_busy && !full && !do_preempt;
  assign rem_dec    = (srv_remaining != '0) ? srv_remaining - 1'b1 : srv_remaining;
  assign do_done    = acc && req.req_type == REQ_TICK && srv_busy && rem_dec == '0;
  assign do_pop     = do_done && !empty;

  // queue entry packing: {started, first_start, arrival, remaining, demand, class}
  logic [DW-1:0]       new_data;
  logic [DEMAND_W-1:0] pre_rem;
  assign pre_rem = (policy == POL_RESTART) ? srv_demand : srv_remaining;
  always_comb begin
    if (do_preempt)
      new_data = {1'b1, srv_first_start, srv_arrival, pre_rem, srv_demand, srv_class};
    else
      new_data = {1'b0, {TW{1'b0}}, now_ticks, req.service_demand,
                  req.service_demand, cls_in};
  end

  row_op_t op;
  assign op = (do_preempt || do_enq) ? ROW_INSERT : (do_pop ? ROW_POP : ROW_HOLD);

  ppjs_row #(.DEPTH(QUEUE_DEPTH), .TW(TW)) u_row (
    .clk(clk), .rst(rst), .op(op), .at_head(do_preempt),
    .ins_class(do_preempt ? srv_class : cls_in), .new_data(new_data),
    .head_data(head_data), .full(full), .empty(empty)
  );

  logic [TW-1:0] now_next;
  assign now_next = now_ticks + 1'b1;

  // head fields
  logic                h_started;
  logic [TW-1:0]       h_fs, h_arr;
  logic [DEMAND_W-1:0] h_rem, h_dem;
  logic [CLASS_W-1:0]  h_cls;
  assign {h_started, h_fs, h_arr, h_rem, h_dem, h_cls} = head_data;

  // server, time and queue count
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0; wait_count <= '0; srv_busy <= 1'b0;
      srv_class <= '0; srv_arrival <= '0; srv_demand <= '0;
      srv_remaining <= '0; srv_first_start <= '0;
    end else if (acc) begin
      if (req.req_type == REQ_TICK) begin
        now_ticks <= now_next;
        if (srv_busy) srv_remaining <= rem_dec;
        if (do_pop) begin
          srv_class <= h_cls; srv_arrival <= h_arr; srv_demand <= h_dem;
          srv_remaining <= h_rem; srv_first_start <= h_started ? h_fs : now_next;
          wait_count <= wait_count - 1'b1;
        end else if (do_done) begin
          srv_busy <= 1'b0; srv_class <= '0; srv_arrival <= '0;
          srv_demand <= '0; srv_remaining <= '0; srv_first_start <= '0;
        end
      end else if (do_load || do_preempt) begin
        srv_busy <= 1'b1; srv_class <= cls_in; srv_arrival <= now_ticks;
        srv_demand <= req.service_demand; srv_remaining <= req.service_demand;
        srv_first_start <= now_ticks;
        if (do_preempt) wait_count <= wait_count + 1'b1;
      end else if (do_enq) begin
        wait_count <= wait_count + 1'b1;
      end
    end
  end

  // result register
  logic [CW-1:0] cnt_after;
  logic          busy_after;
  assign cnt_after  = (do_preempt || do_enq) ? wait_count + 1'b1 :
                      (do_pop ? wait_count - 1'b1 : wait_count);
  assign busy_after = (do_load || do_preempt) ? 1'b1 :
                      ((do_done && empty) ? 1'b0 : srv_busy);
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (acc) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.completed             <= do_done;
      rsp.done_class            <= do_done ? srv_class : '0;
      rsp.response_time         <= do_done ? REPORT_W'(now_next - srv_arrival) : '0;
      rsp.extended_service_time <= do_done ? REPORT_W'(now_next - srv_first_start) : '0;
      rsp.initial_wait          <= do_done ? REPORT_W'(srv_first_start - srv_arrival) : '0;
      rsp.queue_length          <= QLEN_W'(cnt_after);
      rsp.server_busy           <= busy_after;
      rsp.dropped               <= do_drop;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !srv_busy |-> wait_count == '0) else $error("jobs wait while server idle");
  a_full_match: assert property (@(posedge clk) disable iff (rst)
    full == (wait_count == CW'(QUEUE_DEPTH))) else $error("queue full flag mismatch");
`endif
endmodule
